### sv/nsx_pkg.sv
// Shared types, codes and constants for the nibblized SysEx patch receiver.
// Used by every module of the block; depends on nothing.
package nsx_pkg;

	localparam int MOD_SLOTS_DEF  = 8;
	localparam int NAME_BYTES_DEF = 8;
	localparam int HDR_LEN        = 8;
	localparam int QDEPTH         = 2;

	localparam logic [7:0] SYX_START = 8'hF0;
	localparam logic [7:0] SYX_END   = 8'hF7;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_DATA   = 3'd2;
	localparam logic [2:0] PH_FOOTER = 3'd3;
	localparam logic [2:0] PH_OK     = 3'd4;
	localparam logic [2:0] PH_ERROR  = 3'd5;

	typedef struct packed {
		logic       is_read;
		logic [6:0] read_index;
		logic [2:0] status;
		logic       commit;
		logic       wr_en;
		logic [6:0] wr_addr;
		logic [7:0] wr_data;
	} nsx_cmd_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'hF0;
			3'd1: r = 8'h00;
			3'd2: r = 8'h20;
			3'd3: r = 8'h77;
			3'd4: r = 8'h00;
			3'd5: r = 8'h01;
			3'd6: r = 8'h01;
			3'd7: r = 8'h00;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### sv/nibble_sysex_patch_receiver.sv
// Top level of the nibblized SysEx patch receiver: front end, command queue, back end.
// Depends on nsx_pkg, nsx_front, nsx_cmdq and nsx_back.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | operation, midi_byte, read_index
//   output  | out_valid/ out_ready | rx_status, patch_committed, read_data
//
// One beat per cycle is taken in and one result per cycle is given out when not stalled.
// A result passes through the queue and then the result register before it appears.
// The two-entry queue lets the input keep accepting while a result waits on out_ready.
// Reset clears all control state and the store bank flags at once; there is no clearing pass.
module nibble_sysex_patch_receiver #(
	parameter int MOD_SLOTS  = nsx_pkg::MOD_SLOTS_DEF,
	parameter int NAME_BYTES = nsx_pkg::NAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] midi_byte,
	input  logic [6:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] rx_status,
	output logic       patch_committed,
	output logic [7:0] read_data
);
	import nsx_pkg::*;

	logic     push, q_full, pop, q_valid;
	nsx_cmd_t push_cmd, q_cmd;

	nsx_front #(
		.MOD_SLOTS (MOD_SLOTS),
		.NAME_BYTES(NAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.midi_byte (midi_byte),
		.read_index(read_index),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	nsx_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	nsx_back #(
		.MOD_SLOTS (MOD_SLOTS),
		.NAME_BYTES(NAME_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.rx_status      (rx_status),
		.patch_committed(patch_committed),
		.read_data      (read_data)
	);

endmodule

### sv/nsx_front.sv
// Front end: accepts beats, runs the receive state machine and issues commands.
// Depends on nsx_pkg.
module nsx_front #(
	parameter int MOD_SLOTS  = 8,
	parameter int NAME_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [7:0]        midi_byte,
	input  logic [6:0]        read_index,
	output logic              push,
	output nsx_pkg::nsx_cmd_t push_cmd,
	input  logic              q_full
);
	import nsx_pkg::*;

	localparam int PATCH_BYTES = 28 + 2 * MOD_SLOTS + 8 + NAME_BYTES;
	localparam int NAME_START  = 28 + 2 * MOD_SLOTS + 8;
	localparam int DATA_BEATS  = (PATCH_BYTES + 1) * 2;

	logic [2:0] phase_q, phase_nx;
	logic [7:0] cnt_q, cnt_nx;
	logic [7:0] sum_q, sum_nx;
	logic       fault_q, fault_nx;
	logic [3:0] hold_q, hold_nx;
	logic [7:0] cks_q, cks_nx;
	logic [6:0] idx;
	logic [7:0] nib_val;
	logic [7:0] wr_val;
	logic       checked;
	nsx_cmd_t   cmd;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign push_cmd = cmd;

	assign idx     = cnt_q[7:1];
	assign nib_val = {hold_q, midi_byte[3:0]};
	assign wr_val  = cnt_q[0] ? nib_val : {midi_byte[3:0], 4'h0};
	assign checked = (idx >= 7'd6 && idx < 7'd26) ||
		(idx >= 7'(NAME_START) && idx < 7'(NAME_START + NAME_BYTES));

	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		sum_nx   = sum_q;
		fault_nx = fault_q;
		hold_nx  = hold_q;
		cks_nx   = cks_q;
		cmd            = '0;
		cmd.is_read    = operation;
		cmd.read_index = read_index;
		if (!operation) begin
			if (midi_byte == SYX_START) begin
				phase_nx = PH_HEADER;
				cnt_nx   = 8'd0;
				sum_nx   = 8'd0;
				fault_nx = 1'b0;
			end
			case (phase_nx)
				PH_HEADER: begin
					if (cnt_nx < 8'(HDR_LEN) && hdr_byte(cnt_nx[2:0]) == midi_byte) begin
						if (cnt_nx == 8'(HDR_LEN - 1)) begin
							phase_nx = PH_DATA;
							cnt_nx   = 8'd0;
						end else begin
							cnt_nx = cnt_nx + 8'd1;
						end
					end else begin
						phase_nx = PH_FOOTER;
					end
				end
				PH_DATA: begin
					if (!cnt_q[0]) begin
						hold_nx = midi_byte[3:0];
					end
					if (idx == 7'(PATCH_BYTES)) begin
						cks_nx = wr_val;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_addr = idx;
						cmd.wr_data = wr_val;
						if (cnt_q[0]) begin
							sum_nx = sum_q + nib_val;
							if (nib_val > 8'd128 && checked) begin
								fault_nx = 1'b1;
							end
						end
					end
					cnt_nx = cnt_q + 8'd1;
					if ({1'b0, cnt_q} + 9'd1 >= 9'(DATA_BEATS)) begin
						phase_nx = PH_FOOTER;
					end
				end
				PH_FOOTER: begin
					if (midi_byte == SYX_END && sum_q == cks_q && !fault_q) begin
						phase_nx   = PH_OK;
						cmd.commit = 1'b1;
					end else begin
						phase_nx = PH_ERROR;
					end
				end
				default: begin
				end
			endcase
		end
		cmd.status = phase_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 8'd0;
			sum_q   <= 8'd0;
			fault_q <= 1'b0;
			hold_q  <= 4'd0;
			cks_q   <= 8'd0;
		end else if (push) begin
			phase_q <= phase_nx;
			cnt_q   <= cnt_nx;
			sum_q   <= sum_nx;
			fault_q <= fault_nx;
			hold_q  <= hold_nx;
			cks_q   <= cks_nx;
		end
	end

	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> cnt_q < 8'(HDR_LEN))
		else $error("header count out of range");

	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> {1'b0, cnt_q} < 9'(DATA_BEATS))
		else $error("data count past the end of the transfer");

	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd.commit |-> cmd.status == PH_OK && !cmd.wr_en)
		else $error("commit issued without ok status or with a store write");

endmodule

### sv/nsx_cmdq.sv
// Two-entry command queue between the front end and the back end.
// Depends on nsx_pkg.
module nsx_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nsx_pkg::nsx_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output nsx_pkg::nsx_cmd_t q_cmd
);
	import nsx_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	nsx_cmd_t        entry_q [QDEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;

	assign full    = count_q == CW'(QDEPTH);
	assign q_valid = count_q != '0;
	assign q_cmd   = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### sv/nsx_back.sv
// Back end: executes store writes, commits and reads, and holds the result beat.
// Two store banks with per-entry bank flags make a commit a flag copy. Depends on nsx_pkg.
module nsx_back #(
	parameter int MOD_SLOTS  = 8,
	parameter int NAME_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  nsx_pkg::nsx_cmd_t q_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        rx_status,
	output logic              patch_committed,
	output logic [7:0]        read_data
);
	import nsx_pkg::*;

	localparam int PATCH_BYTES = 28 + 2 * MOD_SLOTS + 8 + NAME_BYTES;
	localparam int AW          = $clog2(PATCH_BYTES);

	logic [7:0]             bank_a [PATCH_BYTES];
	logic [7:0]             bank_b [PATCH_BYTES];
	logic [PATCH_BYTES-1:0] cb_q, rb_q, cv_q, rv_q;
	logic [AW-1:0]          waddr, raddr;
	logic                   in_range;
	logic                   wr_a, wr_b;

	logic       valid_s1;
	logic [2:0] status_s1;
	logic       commit_s1;
	logic       is_read_s1;
	logic       hit_s1;
	logic       sel_s1;
	logic [7:0] rd_a_s1, rd_b_s1;

	assign pop      = q_valid && (!valid_s1 || out_ready);
	assign waddr    = q_cmd.wr_addr[AW-1:0];
	assign in_range = q_cmd.read_index < 7'(PATCH_BYTES);
	assign raddr    = in_range ? q_cmd.read_index[AW-1:0] : '0;
	assign wr_a     = pop && q_cmd.wr_en && !cb_q[waddr];
	assign wr_b     = pop && q_cmd.wr_en && cb_q[waddr];

	always_ff @(posedge clk) begin
		if (wr_a) begin
			bank_a[waddr] <= q_cmd.wr_data;
		end
		if (pop) begin
			rd_a_s1 <= bank_a[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			bank_b[waddr] <= q_cmd.wr_data;
		end
		if (pop) begin
			rd_b_s1 <= bank_b[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_s1  <= q_cmd.status;
			commit_s1  <= q_cmd.commit;
			is_read_s1 <= q_cmd.is_read;
			hit_s1     <= q_cmd.is_read && in_range && cv_q[raddr];
			sel_s1     <= cb_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q     <= '0;
			rb_q     <= '0;
			cv_q     <= '0;
			rv_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop && q_cmd.wr_en) begin
				rb_q[waddr] <= !cb_q[waddr];
				rv_q[waddr] <= 1'b1;
			end
			if (pop && q_cmd.commit) begin
				cb_q <= rb_q;
				cv_q <= rv_q;
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign out_valid       = valid_s1;
	assign rx_status       = status_s1;
	assign patch_committed = commit_s1;
	assign read_data       = (is_read_s1 && hit_s1) ? (sel_s1 ? rd_a_s1 : rd_b_s1) : 8'd0;

	a_commit_flags: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_cmd.commit |=> cb_q == rb_q && cv_q == rv_q)
		else $error("commit did not hand the receive banks to the committed view");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_read_s1 |-> read_data == 8'd0)
		else $error("read data nonzero on a receive beat");

	a_commit_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && patch_committed |-> rx_status == PH_OK && !is_read_s1)
		else $error("commit flagged without ok status");

endmodule
